>>> hdl/wdec_pkg.sv
// shared types and codes for the window decimator
// used by wdec_front, wdec_back and window_decimator; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package wdec_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd1;

    // mode register codes
    localparam logic [1:0] MODE_KEEP   = 2'd0;
    localparam logic [1:0] MODE_AVG    = 2'd1;
    localparam logic [1:0] MODE_MINMAX = 2'd2;

    // result kind codes
    localparam logic [1:0] KIND_KEEP = 2'd0;
    localparam logic [1:0] KIND_AVG  = 2'd1;
    localparam logic [1:0] KIND_MIN  = 2'd2;
    localparam logic [1:0] KIND_MAX  = 2'd3;

    // job type passed through the queue
    typedef enum logic [1:0] {
        OP_KEEP   = 2'd0,
        OP_AVG    = 2'd1,
        OP_MINMAX = 2'd2
    } t_op;

    localparam int OP_W = 2;

    // back part sequencer
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIV    = 4'b0010,
        S_EMIT_A = 4'b0100,
        S_EMIT_B = 4'b1000
    } t_back_state;

endpackage

`default_nettype wire

>>> hdl/wdec_fifo.sv
// two-entry job queue between the front and back parts
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module wdec_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

>>> hdl/wdec_front.sv
// front part: configuration registers, window tracking, job generation
// depends on wdec_pkg
`timescale 1ns / 1ps
`default_nettype none

module wdec_front #(
    parameter int WINDOW_MAX   = 1024,
    parameter int SAMPLE_WIDTH = 32,
    parameter int LEN_W        = 11,
    parameter int POS_W        = 10,
    parameter int SUM_W        = 42
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wdec_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [wdec_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  wire logic                              i_end_of_block,
    input  wire logic                              i_q_full,
    output logic                                   o_push,
    output wdec_pkg::t_op                          o_op,
    output logic [LEN_W-1:0]                       o_len,
    output logic signed [SUM_W-1:0]                o_sum,
    output logic signed [SAMPLE_WIDTH-1:0]         o_va,
    output logic signed [SAMPLE_WIDTH-1:0]         o_vb
);

    logic [1:0]                        r_mode;
    logic [wdec_pkg::CFG_DATA_W-1:0]   r_len_cfg;
    logic [POS_W-1:0]                  r_pos;
    logic signed [SUM_W-1:0]           r_sum;
    logic signed [SAMPLE_WIDTH-1:0]    r_min;
    logic signed [SAMPLE_WIDTH-1:0]    r_max;

    logic signed [SUM_W-1:0]           n_sum;
    logic signed [SAMPLE_WIDTH-1:0]    n_min;
    logic signed [SAMPLE_WIDTH-1:0]    n_max;

    logic [31:0]      w_len32;
    logic [LEN_W-1:0] w_len;
    logic             w_first;
    logic             w_done;
    logic             w_accept;
    logic             w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign o_ready     = !i_q_full;
    assign w_accept    = i_valid && o_ready;

    // zero length acts as one, long windows saturate
    always_comb begin
        if (r_len_cfg == '0) begin
            w_len32 = 32'd1;
        end else if (32'(r_len_cfg) > 32'(WINDOW_MAX)) begin
            w_len32 = 32'(WINDOW_MAX);
        end else begin
            w_len32 = 32'(r_len_cfg);
        end
    end
    assign w_len = w_len32[LEN_W-1:0];

    assign w_first = r_pos == '0;
    assign w_done  = (LEN_W'(r_pos) + LEN_W'(1)) >= w_len;

    always_comb begin
        if (w_first) begin
            n_sum = SUM_W'(i_sample);
            n_min = i_sample;
            n_max = i_sample;
        end else begin
            n_sum = r_sum + SUM_W'(i_sample);
            n_min = (i_sample < r_min) ? i_sample : r_min;
            n_max = (i_sample > r_max) ? i_sample : r_max;
        end
    end

    always_comb begin
        o_push = 1'b0;
        o_op   = wdec_pkg::OP_KEEP;
        o_va   = n_min;
        unique case (r_mode)
            wdec_pkg::MODE_KEEP: begin
                o_push = w_accept && w_first;
                o_va   = i_sample;
            end
            wdec_pkg::MODE_AVG: begin
                o_push = w_accept && w_done;
                o_op   = wdec_pkg::OP_AVG;
            end
            wdec_pkg::MODE_MINMAX: begin
                o_push = w_accept && w_done;
                o_op   = wdec_pkg::OP_MINMAX;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    assign o_len = w_len;
    assign o_sum = n_sum;
    assign o_vb  = n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= wdec_pkg::MODE_AVG;
            r_len_cfg <= wdec_pkg::CFG_DATA_W'(1);
            r_pos     <= '0;
        end else if (w_cfg_wr) begin
            // a write to the mode or window length register drops the window in progress
            if (i_cfg_index == wdec_pkg::REG_MODE) begin
                r_mode <= i_cfg_data[1:0];
                r_pos  <= '0;
            end else if (i_cfg_index == wdec_pkg::REG_WINDOW_LENGTH) begin
                r_len_cfg <= i_cfg_data;
                r_pos     <= '0;
            end
        end else if (w_accept) begin
            if (w_done || i_end_of_block) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sum <= n_sum;
            r_min <= n_min;
            r_max <= n_max;
        end
    end

endmodule

`default_nettype wire

>>> hdl/wdec_back.sv
// back part: pops jobs, runs the restoring divider, drives the result register
// depends on wdec_pkg
`timescale 1ns / 1ps
`default_nettype none

module wdec_back #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int LEN_W        = 11,
    parameter int SUM_W        = 42
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_valid,
    output logic                                o_q_pop,
    input  wire wdec_pkg::t_op                  i_op,
    input  wire logic [LEN_W-1:0]               i_len,
    input  wire logic signed [SUM_W-1:0]        i_sum,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_va,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_vb,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_value,
    output logic [1:0]                          o_kind,
    output logic                                o_last_of_run,
    output logic [15:0]                         o_sequence_res
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    wdec_pkg::t_back_state r_state;
    wdec_pkg::t_back_state n_state;

    wdec_pkg::t_op                  r_op;
    logic signed [SAMPLE_WIDTH-1:0] r_va;
    logic signed [SAMPLE_WIDTH-1:0] r_vb;
    logic [LEN_W-1:0]               r_len;
    logic                           r_neg;
    logic [SUM_W-1:0]               r_quo;
    logic [LEN_W-1:0]               r_rem;
    logic [CNT_W-1:0]               r_cnt;
    logic [15:0]                    r_seq;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic [1:0]                     r_kind;
    logic                           r_last;

    logic [LEN_W:0]      w_shift;
    logic [LEN_W:0]      w_diff;
    logic                w_ge;
    logic [SUM_W-1:0]    w_quo_signed;
    logic                w_out_free;
    logic                w_load;
    logic signed [SAMPLE_WIDTH-1:0] w_value;
    logic [1:0]          w_kind;
    logic                w_last;

    assign w_out_free = !r_out_valid || i_ready;

    // one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_len};
    assign w_ge    = w_shift >= {1'b0, r_len};

    // truncation toward zero: divide magnitudes, then restore the sign
    assign w_quo_signed = r_neg ? ('0 - r_quo) : r_quo;

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        w_load  = 1'b0;
        w_value = r_va;
        w_kind  = wdec_pkg::KIND_KEEP;
        w_last  = 1'b1;
        unique case (r_state)
            wdec_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = (i_op == wdec_pkg::OP_AVG) ? wdec_pkg::S_DIV
                                                         : wdec_pkg::S_EMIT_A;
                end
            end
            wdec_pkg::S_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = wdec_pkg::S_EMIT_A;
                end
            end
            wdec_pkg::S_EMIT_A: begin
                w_load = w_out_free;
                unique case (r_op)
                    wdec_pkg::OP_AVG: begin
                        w_value = w_quo_signed[SAMPLE_WIDTH-1:0];
                        w_kind  = wdec_pkg::KIND_AVG;
                    end
                    wdec_pkg::OP_MINMAX: begin
                        w_kind = wdec_pkg::KIND_MIN;
                        w_last = 1'b0;
                    end
                    default: begin
                        w_kind = wdec_pkg::KIND_KEEP;
                    end
                endcase
                if (w_out_free) begin
                    n_state = (r_op == wdec_pkg::OP_MINMAX) ? wdec_pkg::S_EMIT_B
                                                            : wdec_pkg::S_IDLE;
                end
            end
            wdec_pkg::S_EMIT_B: begin
                w_load  = w_out_free;
                w_value = r_vb;
                w_kind  = wdec_pkg::KIND_MAX;
                if (w_out_free) begin
                    n_state = wdec_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wdec_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wdec_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_seq       <= 16'd0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_seq       <= r_seq + 16'd1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_cnt <= CNT_W'(SUM_W);
            end else if (r_state == wdec_pkg::S_DIV) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op  <= i_op;
            r_va  <= i_va;
            r_vb  <= i_vb;
            r_len <= i_len;
            r_neg <= i_sum[SUM_W-1];
            r_quo <= i_sum[SUM_W-1] ? ('0 - i_sum) : i_sum;
            r_rem <= '0;
        end else if (r_state == wdec_pkg::S_DIV) begin
            r_rem <= w_ge ? w_diff[LEN_W-1:0] : w_shift[LEN_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
        if (w_load) begin
            r_value        <= w_value;
            r_kind         <= w_kind;
            r_last         <= w_last;
            o_sequence_res <= r_seq;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_value       = r_value;
    assign o_kind        = r_kind;
    assign o_last_of_run = r_last;

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=>
            (!o_valid || o_sequence_res == 16'($past(o_sequence_res) + 16'd1)))
        else $error("result sequence number skipped or repeated");

    a_min_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wdec_pkg::KIND_MIN) |-> !o_last_of_run)
        else $error("minimum marked as last of run");

    a_max_after_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_kind == wdec_pkg::KIND_MIN) |=>
            (r_state == wdec_pkg::S_IDLE && o_valid && o_kind == wdec_pkg::KIND_MAX))
        else $error("minimum not followed by its maximum");

endmodule

`default_nettype wire

>>> hdl/window_decimator.sv
// path: a job from the front part goes through the job queue to the back part, which
//   pops it when idle and loads the result register; averages pass the divider first
// throughput: one sample per cycle while the two-entry job queue has room; the back part
//   pops a new job only from its idle state, once the last job's results are loaded
// reset: synchronous, active low; mode 1, window length 1, queue and result empty
`timescale 1ns / 1ps
`default_nettype none

module window_decimator #(
    parameter int WINDOW_MAX   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wdec_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [wdec_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  wire logic                              i_end_of_block,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         o_value,
    output logic [1:0]                             o_kind,
    output logic                                   o_last_of_run,
    output logic [15:0]                            o_sequence_res
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int POS_W = $clog2(WINDOW_MAX);
    localparam int SUM_W = SAMPLE_WIDTH + POS_W;
    localparam int JOB_W = wdec_pkg::OP_W + LEN_W + SUM_W + 2 * SAMPLE_WIDTH;

    logic                           w_push;
    logic                           w_q_full;
    logic                           w_q_valid;
    logic                           w_q_pop;
    wdec_pkg::t_op                  w_f_op;
    logic [LEN_W-1:0]               w_f_len;
    logic signed [SUM_W-1:0]        w_f_sum;
    logic signed [SAMPLE_WIDTH-1:0] w_f_va;
    logic signed [SAMPLE_WIDTH-1:0] w_f_vb;
    logic [JOB_W-1:0]               w_job_in;
    logic [JOB_W-1:0]               w_job_out;

    wdec_front #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LEN_W        (LEN_W),
        .POS_W        (POS_W),
        .SUM_W        (SUM_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .i_end_of_block (i_end_of_block),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_op           (w_f_op),
        .o_len          (w_f_len),
        .o_sum          (w_f_sum),
        .o_va           (w_f_va),
        .o_vb           (w_f_vb)
    );

    assign w_job_in = {w_f_op, w_f_len, w_f_sum, w_f_va, w_f_vb};

    wdec_fifo #(
        .W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_job_out)
    );

    wdec_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LEN_W        (LEN_W),
        .SUM_W        (SUM_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .o_q_pop        (w_q_pop),
        .i_op           (wdec_pkg::t_op'(w_job_out[JOB_W-1 -: wdec_pkg::OP_W])),
        .i_len          (w_job_out[2*SAMPLE_WIDTH+SUM_W +: LEN_W]),
        .i_sum          (w_job_out[2*SAMPLE_WIDTH +: SUM_W]),
        .i_va           (w_job_out[SAMPLE_WIDTH +: SAMPLE_WIDTH]),
        .i_vb           (w_job_out[0 +: SAMPLE_WIDTH]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_value        (o_value),
        .o_kind         (o_kind),
        .o_last_of_run  (o_last_of_run),
        .o_sequence_res (o_sequence_res)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for window_decimator: directed and random sample streams
// over all modes and a range of window lengths, results checked against an in-bench predictor
// depends on hdl/wdec_pkg.sv and hdl/window_decimator.sv
`timescale 1ns / 1ps

module tb;

    localparam int WINDOW_MAX   = 1024;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1000000;

    // register index and mode codes that the block leaves unused
    localparam logic [wdec_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [wdec_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [1:0]                       MODE_NONE   = 2'd3;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         kind;
        logic               last;
        logic [15:0]        seq;
    } t_dec_out;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [wdec_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [wdec_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_valid;
    logic                             o_ready;
    logic signed [31:0]               i_sample;
    logic                             i_end_of_block;
    logic                             o_valid;
    logic                             i_ready;
    logic signed [31:0]               o_value;
    logic [1:0]                       o_kind;
    logic                             o_last_of_run;
    logic [15:0]                      o_sequence_res;

    // predictor state
    logic [1:0]         cfg_mode;
    logic [10:0]        cfg_len;
    int unsigned        win_pos;
    longint             win_sum;
    logic signed [31:0] win_min;
    logic signed [31:0] win_max;
    logic [15:0]        next_seq;
    t_dec_out           due_outputs[$];

    int fail_count;
    int checked_count;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_off_cycles;
    int cycle_count;

    window_decimator #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(32)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_end_of_block(i_end_of_block),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_value       (o_value),
        .o_kind        (o_kind),
        .o_last_of_run (o_last_of_run),
        .o_sequence_res(o_sequence_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s at result %0d, got %h want %h", what, checked_count, got, want);
        fail_count++;
    endtask

    function automatic void queue_output(input logic signed [31:0] v, input logic [1:0] k,
                                         input logic l);
        due_outputs.push_back('{v, k, l, next_seq});
        next_seq++;
    endfunction

    function automatic void restart_window();
        win_pos = 0;
        win_sum = 0;
        win_min = '0;
        win_max = '0;
    endfunction

    // works out the results that one accepted sample causes
    function automatic void decimate(input logic signed [31:0] s, input logic eob);
        int unsigned len;
        logic        first;
        logic        done;
        len = (cfg_len == 0) ? 1 : ((cfg_len > WINDOW_MAX) ? WINDOW_MAX : cfg_len);
        first = (win_pos == 0);
        if (first) begin
            win_sum = s;
            win_min = s;
            win_max = s;
        end else begin
            win_sum += s;
            if (s < win_min) win_min = s;
            if (s > win_max) win_max = s;
        end
        done = (win_pos + 1 >= len);
        case (cfg_mode)
            wdec_pkg::MODE_KEEP: begin
                if (first) queue_output(s, wdec_pkg::KIND_KEEP, 1'b1);
            end
            wdec_pkg::MODE_AVG: begin
                if (done)
                    queue_output(32'(win_sum / longint'(len)), wdec_pkg::KIND_AVG, 1'b1);
            end
            wdec_pkg::MODE_MINMAX: begin
                if (done) begin
                    queue_output(win_min, wdec_pkg::KIND_MIN, 1'b0);
                    queue_output(win_max, wdec_pkg::KIND_MAX, 1'b1);
                end
            end
            default: ;
        endcase
        win_pos = (done || eob) ? 0 : win_pos + 1;
    endfunction

    // result check first, then configuration and sample transfers of the same edge
    always @(posedge i_clk) begin : check_outputs
        t_dec_out head;
        if (!i_rst_n) begin
            cfg_mode = wdec_pkg::MODE_AVG;
            cfg_len  = 11'd1;
            next_seq = '0;
            restart_window();
        end else begin
            if (o_valid && i_ready) begin
                if (due_outputs.size() == 0) begin
                    report_mismatch("unexpected result", o_value, '0);
                end else begin
                    head = due_outputs.pop_front();
                    if (o_value !== head.value)
                        report_mismatch("value", o_value, head.value);
                    if (o_kind !== head.kind)
                        report_mismatch("kind", 32'(o_kind), 32'(head.kind));
                    if (o_last_of_run !== head.last)
                        report_mismatch("last_of_run", 32'(o_last_of_run), 32'(head.last));
                    if (o_sequence_res !== head.seq)
                        report_mismatch("sequence_res", 32'(o_sequence_res), 32'(head.seq));
                end
                checked_count++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    wdec_pkg::REG_MODE: begin
                        cfg_mode = i_cfg_data[1:0];
                        restart_window();
                    end
                    wdec_pkg::REG_WINDOW_LENGTH: begin
                        cfg_len = i_cfg_data;
                        restart_window();
                    end
                    default: ;
                endcase
            end
            if (i_valid && o_ready)
                decimate(i_sample, i_end_of_block);
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin : receiver
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_ready = 1'b0;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
            end
            i_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_sample(input logic signed [31:0] s, input logic eob);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_sample       = s;
        i_end_of_block = eob;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_quiet();
        while (due_outputs.size() != 0) @(negedge i_clk);
        // samples that cause no result may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [wdec_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [wdec_pkg::CFG_DATA_W-1:0] data);
        wait_quiet();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        // mode average with window 1 out of reset: each sample comes back unchanged
        send_sample(32'sh7FFFFFFF, 1'b0);
        send_sample(32'sh80000000, 1'b1);
        send_sample(-32'sd1, 1'b0);
    endtask

    task automatic test_keep_first();
        write_reg(wdec_pkg::REG_MODE, {9'd0, wdec_pkg::MODE_KEEP});
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd3);
        send_sample(32'sd11, 1'b0);
        send_sample(32'sd12, 1'b1);     // partial window, next sample starts a new one
        send_sample(32'sd13, 1'b0);
        send_sample(32'sd14, 1'b0);
        send_sample(32'sd15, 1'b0);
        send_sample(32'sd16, 1'b0);     // trailing partial window still kept
    endtask

    task automatic test_average();
        write_reg(wdec_pkg::REG_MODE, {9'd0, wdec_pkg::MODE_AVG});
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd4);
        // negative sum truncates toward zero
        send_sample(-32'sd7, 1'b0);
        repeat (3) send_sample(32'sd0, 1'b0);
        repeat (4) send_sample(32'sh7FFFFFFF, 1'b0);
        repeat (4) send_sample(32'sh80000000, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd6, 1'b1);      // dropped partial window
    endtask

    task automatic test_min_max();
        write_reg(wdec_pkg::REG_MODE, {9'd0, wdec_pkg::MODE_MINMAX});
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd3);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7FFFFFFF, 1'b0);
        send_sample(32'sd3, 1'b1);
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd0);    // zero length behaves as one
        send_sample(-32'sd9, 1'b0);
        send_sample(32'sd9, 1'b1);
    endtask

    task automatic test_unused_codes();
        write_reg(wdec_pkg::REG_MODE, {9'd0, MODE_NONE});
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd2);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd2, 1'b1);
        send_sample(32'sd3, 1'b0);
        write_reg(wdec_pkg::REG_MODE, {9'd0, wdec_pkg::MODE_AVG});
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd4);
        send_sample(32'sd100, 1'b0);
        send_sample(-32'sd37, 1'b0);
        // writes to spare indexes must leave the open window alone
        write_reg(REG_SPARE_A, 11'h7FF);
        write_reg(REG_SPARE_B, 11'h2AA);
        send_sample(32'sd55, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd999, 1'b0);
        // rewriting the length drops the window just opened
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd4);
        repeat (4) send_sample(pick_sample(), 1'b0);
    endtask

    task automatic test_long_window();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_reg(wdec_pkg::REG_MODE, {9'd0, wdec_pkg::MODE_AVG});
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd200);
        repeat (200) send_sample(pick_sample(), 1'b0);
        // beyond the largest window: the block ends before the window fills, so nothing comes out
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd2047);
        repeat (5) send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b1);
        write_reg(wdec_pkg::REG_MODE, {9'd0, wdec_pkg::MODE_KEEP});
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd2047);
        send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b1);
        send_sample(pick_sample(), 1'b0);
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_reg(wdec_pkg::REG_MODE, {9'd0, wdec_pkg::MODE_MINMAX});
        write_reg(wdec_pkg::REG_WINDOW_LENGTH, 11'd1);
        hold_off_cycles = 300;
        @(negedge i_clk);
        repeat (40) send_sample(pick_sample(), $urandom_range(0, 1));
    endtask

    task automatic run_random_segment(input int n_items);
        logic [1:0]  mode;
        logic [10:0] len;
        int          wlen;
        int          blk;
        int          sent;
        case ($urandom_range(0, 9))
            0, 1, 2: mode = wdec_pkg::MODE_KEEP;
            3, 4, 5: mode = wdec_pkg::MODE_AVG;
            6, 7, 8: mode = wdec_pkg::MODE_MINMAX;
            default: mode = MODE_NONE;
        endcase
        case ($urandom_range(0, 19))
            0:       len = 11'd0;
            1, 2, 3: len = 11'($urandom_range(7, 48));
            default: len = 11'($urandom_range(1, 6));
        endcase
        if ($urandom_range(0, 1)) begin
            write_reg(wdec_pkg::REG_MODE, {9'($urandom), mode});
            write_reg(wdec_pkg::REG_WINDOW_LENGTH, len);
        end else begin
            write_reg(wdec_pkg::REG_WINDOW_LENGTH, len);
            write_reg(wdec_pkg::REG_MODE, {9'($urandom), mode});
        end
        wlen = (len == 0) ? 1 : len;
        sent = 0;
        while (sent < n_items) begin
            // mostly whole windows closed by an end of block, some ragged blocks
            if ($urandom_range(0, 3) != 0)
                blk = wlen * $urandom_range(1, 3);
            else
                blk = $urandom_range(1, 2 * wlen + 1);
            for (int i = 0; i < blk; i++)
                send_sample(pick_sample(), (i == blk - 1) || ($urandom_range(0, 39) == 0));
            sent += blk;
        end
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (3) run_random_segment(35);
    endtask

    initial begin : main
        fail_count      = 0;
        checked_count   = 0;
        cycle_count     = 0;
        hold_off_cycles = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_sample        = '0;
        i_end_of_block  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = wdec_pkg::REG_MODE;
        i_cfg_data      = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_keep_first();
        test_average();
        test_min_max();
        test_unused_codes();
        test_long_window();
        test_backpressure();
        test_random(0, 0);
        test_random(73, 0);
        test_random(0, 73);
        test_random(35, 35);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        wait_quiet();
        if (fail_count == 0 && due_outputs.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> window_decimator.f
hdl/wdec_pkg.sv
hdl/wdec_fifo.sv
hdl/wdec_front.sv
hdl/wdec_back.sv
hdl/window_decimator.sv
tb/tb.sv
